/* rtl/cpu8_pkg.sv */
// shared types, opcode classes and decode function for the 8-bit cpu execute unit
`default_nettype none
package cpu8_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] FlagC = 8'h01;
  localparam logic [7:0] FlagZ = 8'h02;
  localparam logic [7:0] FlagI = 8'h04;
  localparam logic [7:0] FlagD = 8'h08;
  localparam logic [7:0] FlagB = 8'h10;
  localparam logic [7:0] FlagU = 8'h20;
  localparam logic [7:0] FlagV = 8'h40;
  localparam logic [7:0] FlagN = 8'h80;

  localparam logic [1:0] ErrOk = 2'd0;
  localparam logic [1:0] ErrUndef = 2'd1;
  localparam logic [1:0] ErrDecimal = 2'd2;
  localparam logic [1:0] ErrControl = 2'd3;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0] write_data;
    logic       write_valid;
    logic [7:0] stack_index;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] flags_out;
    logic [1:0] error_code;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY,
    OP_BIT, OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_SHA, OP_SHM,
    OP_INC, OP_DEC, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_TAX, OP_TAY, OP_TXA,
    OP_TYA, OP_TSX, OP_TXS, OP_FLAG, OP_STACK
  } op_class_t;

  // decoded transaction handed from front to back
  typedef struct packed {
    op_class_t  cls;
    logic [7:0] opcode;
    logic [7:0] operand;
    logic       branch;
    logic [1:0] err;
  } dec_item_t;

  function automatic dec_item_t decode(input in_item_t it);
    dec_item_t d;
    d.opcode = it.opcode;
    d.operand = it.operand;
    d.branch = 1'b0;
    d.err = ErrOk;
    d.cls = OP_NOP;
    case (it.opcode)
      8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: d.cls = OP_ORA;
      8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: d.cls = OP_AND;
      8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: d.cls = OP_EOR;
      8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: d.cls = OP_ADC;
      8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: d.cls = OP_SBC;
      8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: d.cls = OP_CMP;
      8'hE0, 8'hE4, 8'hEC: d.cls = OP_CPX;
      8'hC0, 8'hC4, 8'hCC: d.cls = OP_CPY;
      8'h24, 8'h2C: d.cls = OP_BIT;
      8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: d.cls = OP_LDA;
      8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: d.cls = OP_LDX;
      8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: d.cls = OP_LDY;
      8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: d.cls = OP_STA;
      8'h86, 8'h8E, 8'h96: d.cls = OP_STX;
      8'h84, 8'h8C, 8'h94: d.cls = OP_STY;
      8'h0A, 8'h2A, 8'h4A, 8'h6A: d.cls = OP_SHA;
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
      8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: d.cls = OP_SHM;
      8'hE6, 8'hEE, 8'hF6, 8'hFE: d.cls = OP_INC;
      8'hC6, 8'hCE, 8'hD6, 8'hDE: d.cls = OP_DEC;
      8'hE8: d.cls = OP_INX;
      8'hC8: d.cls = OP_INY;
      8'hCA: d.cls = OP_DEX;
      8'h88: d.cls = OP_DEY;
      8'hAA: d.cls = OP_TAX;
      8'hA8: d.cls = OP_TAY;
      8'h8A: d.cls = OP_TXA;
      8'h98: d.cls = OP_TYA;
      8'hBA: d.cls = OP_TSX;
      8'h9A: d.cls = OP_TXS;
      8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8: d.cls = OP_FLAG;
      8'h48, 8'h08, 8'h68, 8'h28: d.cls = OP_STACK;
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: d.branch = 1'b1;
      8'hEA: d.cls = OP_NOP;
      8'h00, 8'h20, 8'h40, 8'h4C, 8'h60, 8'h6C, 8'hEF: d.err = ErrControl;
      default: d.err = ErrUndef;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/cpu8_front.sv */
// front end: accepts transactions, decodes them and fills the decoupling queue
`default_nettype none
module cpu8_front #(
  parameter int unsigned Depth = cpu8_pkg::QueueDepth
) (
  input  wire                   clk,
  input  wire                   rst,
  input  cpu8_pkg::in_item_t    in_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  output cpu8_pkg::dec_item_t   q_data,
  output logic                  q_valid,
  input  wire                   q_ready
);
  import cpu8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dec_item_t       slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready = (count != CntW'(Depth));
  assign q_valid  = (count != '0);
  assign q_data   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decode(in_data);
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/cpu8_back.sv */
// back end: register file, alu execution and output register
`default_nettype none
module cpu8_back (
  input  wire                   clk,
  input  wire                   rst,
  input  cpu8_pkg::dec_item_t   q_data,
  input  wire                   q_valid,
  output logic                  q_ready,
  output cpu8_pkg::out_item_t   out_data,
  output logic                  out_valid,
  input  wire                   out_ready
);
  import cpu8_pkg::*;

  logic [7:0] acc, idx_x, idx_y, sp, flags;
  logic [7:0] acc_next, x_next, y_next, sp_next, flags_next;
  out_item_t  res;
  logic       fire;

  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;

  // execute one decoded transaction
  always_comb begin
    logic [7:0] v, r, sr, d;
    logic [8:0] sum;
    logic       cin;
    logic       setnz;
    logic [7:0] nzv;
    v = q_data.operand;
    sr = flags;
    cin = sr[0];
    acc_next = acc;
    x_next = idx_x;
    y_next = idx_y;
    sp_next = sp;
    flags_next = flags;
    setnz = 1'b0;
    nzv = 8'h00;
    r = 8'h00;
    sum = 9'h000;
    d = 8'h00;
    res = '0;
    res.error_code = q_data.err;
    case (q_data.cls)
      OP_ORA: begin acc_next = acc | v; nzv = acc_next; setnz = 1'b1; end
      OP_AND: begin acc_next = acc & v; nzv = acc_next; setnz = 1'b1; end
      OP_EOR: begin acc_next = acc ^ v; nzv = acc_next; setnz = 1'b1; end
      OP_ADC, OP_SBC: begin
        if (sr[3]) begin
          res.error_code = ErrDecimal;
        end else begin
          d = (q_data.cls == OP_SBC) ? ~v : v;
          sum = {1'b0, acc} + {1'b0, d} + {8'h00, cin};
          r = sum[7:0];
          acc_next = r;
          flags_next[6] = ~(acc[7] ^ d[7]) & (acc[7] ^ r[7]);
          flags_next[0] = sum[8];
          nzv = r;
          setnz = 1'b1;
        end
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        d = (q_data.cls == OP_CMP) ? acc : (q_data.cls == OP_CPX) ? idx_x : idx_y;
        sum = {1'b0, d} - {1'b0, v};
        flags_next[0] = !sum[8];
        nzv = sum[7:0];
        setnz = 1'b1;
      end
      OP_BIT: begin
        flags_next[7] = v[7];
        flags_next[6] = v[6];
        flags_next[1] = ((acc & v) == 8'h00);
      end
      OP_LDA: begin acc_next = v; nzv = v; setnz = 1'b1; end
      OP_LDX: begin x_next = v; nzv = v; setnz = 1'b1; end
      OP_LDY: begin y_next = v; nzv = v; setnz = 1'b1; end
      OP_STA: begin res.write_data = acc; res.write_valid = 1'b1; end
      OP_STX: begin res.write_data = idx_x; res.write_valid = 1'b1; end
      OP_STY: begin res.write_data = idx_y; res.write_valid = 1'b1; end
      OP_SHA, OP_SHM: begin
        d = (q_data.cls == OP_SHA) ? acc : v;
        case (q_data.opcode[6:5])
          2'd0: begin r = {d[6:0], 1'b0}; flags_next[0] = d[7]; end
          2'd1: begin r = {d[6:0], cin}; flags_next[0] = d[7]; end
          2'd2: begin r = {1'b0, d[7:1]}; flags_next[0] = d[0]; end
          default: begin r = {cin, d[7:1]}; flags_next[0] = d[0]; end
        endcase
        nzv = r;
        setnz = 1'b1;
        if (q_data.cls == OP_SHA) begin
          acc_next = r;
        end else begin
          res.write_data = r;
          res.write_valid = 1'b1;
        end
      end
      OP_INC: begin
        r = v + 8'd1; res.write_data = r; res.write_valid = 1'b1; nzv = r; setnz = 1'b1;
      end
      OP_DEC: begin
        r = v - 8'd1; res.write_data = r; res.write_valid = 1'b1; nzv = r; setnz = 1'b1;
      end
      OP_INX: begin x_next = idx_x + 8'd1; nzv = x_next; setnz = 1'b1; end
      OP_INY: begin y_next = idx_y + 8'd1; nzv = y_next; setnz = 1'b1; end
      OP_DEX: begin x_next = idx_x - 8'd1; nzv = x_next; setnz = 1'b1; end
      OP_DEY: begin y_next = idx_y - 8'd1; nzv = y_next; setnz = 1'b1; end
      OP_TAX: begin x_next = acc; nzv = acc; setnz = 1'b1; end
      OP_TAY: begin y_next = acc; nzv = acc; setnz = 1'b1; end
      OP_TXA: begin acc_next = idx_x; nzv = idx_x; setnz = 1'b1; end
      OP_TYA: begin acc_next = idx_y; nzv = idx_y; setnz = 1'b1; end
      OP_TSX: begin x_next = sp; nzv = sp; setnz = 1'b1; end
      OP_TXS: sp_next = idx_x;
      OP_FLAG: begin
        case (q_data.opcode[7:5])
          3'd0: flags_next[0] = 1'b0;
          3'd1: flags_next[0] = 1'b1;
          3'd2: flags_next[2] = 1'b0;
          3'd3: flags_next[2] = 1'b1;
          3'd5: flags_next[6] = 1'b0;
          3'd6: flags_next[3] = 1'b0;
          default: flags_next[3] = 1'b1;
        endcase
      end
      OP_STACK: begin
        if (!q_data.opcode[5]) begin
          // push accumulator or status
          res.write_data = q_data.opcode[6] ? acc : (sr | FlagB | FlagU);
          res.write_valid = 1'b1;
          res.stack_index = sp;
          sp_next = sp - 8'd1;
        end else begin
          // pull accumulator or status
          sp_next = sp + 8'd1;
          res.stack_index = sp_next;
          if (q_data.opcode[6]) begin
            acc_next = v; nzv = v; setnz = 1'b1;
          end else begin
            flags_next = v & ~(FlagB | FlagU);
          end
        end
      end
      default: ;
    endcase
    if (setnz) begin
      flags_next[7] = nzv[7];
      flags_next[1] = (nzv == 8'h00);
    end
    // branch condition from opcode bits 7:6 (flag) and bit 5 (polarity)
    if (q_data.branch) begin
      case (q_data.opcode[7:6])
        2'd0: res.branch_taken = (sr[7] == q_data.opcode[5]);
        2'd1: res.branch_taken = (sr[6] == q_data.opcode[5]);
        2'd2: res.branch_taken = (sr[0] == q_data.opcode[5]);
        default: res.branch_taken = (sr[1] == q_data.opcode[5]);
      endcase
    end
    res.acc_out = acc_next;
    res.x_out = x_next;
    res.y_out = y_next;
    res.flags_out = flags_next;
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'h00;
      idx_x <= 8'h00;
      idx_y <= 8'h00;
      sp <= 8'hFF;
      flags <= 8'h00;
    end else if (fire) begin
      acc <= acc_next;
      idx_x <= x_next;
      idx_y <= y_next;
      sp <= sp_next;
      flags <= flags_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* rtl/cpu8_register_alu_execute.sv */
// top level of the 8-bit cpu register and alu execute unit
`default_nettype none
// Executes one resolved instruction (opcode plus operand) per clock cycle at
// full throughput unless out_ready stalls it: a decode front end feeds a small
// queue (QueueDepth entries), the back end executes one entry per cycle into
// an output register; each item is registered in a queue slot, then in the
// output register. The back end holds A, X, Y, SP and the status byte; reset gives SP 0xFF, others 0.
module cpu8_register_alu_execute #(
  parameter int unsigned QueueDepth = cpu8_pkg::QueueDepth
) (
  input  wire                  clk,
  input  wire                  rst,
  input  cpu8_pkg::in_item_t   in_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  output cpu8_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  wire                  out_ready
);
  import cpu8_pkg::*;

  dec_item_t q_data;
  logic      q_valid;
  logic      q_ready;

  cpu8_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
  );

  cpu8_back u_back (
    .clk(clk), .rst(rst),
    .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

endmodule
`default_nettype wire
